/* hw/rtl/ppusar_pkg.sv */
package ppusar_pkg;

    typedef enum logic [3:0] {
        CMD_BUS_WRITE  = 4'd0,
        CMD_BUS_READ   = 4'd1,
        CMD_INC_X      = 4'd2,
        CMD_INC_Y      = 4'd3,
        CMD_COPY_HORIZ = 4'd4,
        CMD_COPY_VERT  = 4'd5,
        CMD_SET_VBLANK = 4'd6,
        CMD_FRAME_ST   = 4'd7,
        CMD_NMI_ACK    = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_READ  = 2'd1,
        MEM_WRITE = 2'd2
    } t_mem_op;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [13:0] ADDR_PALETTE = 14'h3F00;
    localparam logic [13:0] ADDR_NT_LAST = 14'h2FFF;
    localparam logic [13:0] INC_ACROSS   = 14'd1;
    localparam logic [13:0] INC_DOWN     = 14'd32;
    localparam logic [4:0]  COARSE_LAST  = 5'd31;
    localparam logic [4:0]  ROW_LAST     = 5'd29;
    localparam logic [2:0]  FINE_LAST    = 3'd7;

    typedef struct packed {
        logic [3:0] command;
        logic [2:0] reg_index;
        logic [7:0] bus_data;
        logic [7:0] mem_byte;
        logic [7:0] mem_byte_below;
    } t_req;

    typedef struct packed {
        logic [7:0]  read_data;
        t_mem_op     mem_op;
        logic [13:0] mem_addr;
        logic [7:0]  mem_wdata;
        logic [14:0] vram_addr;
        logic [2:0]  fine_x_out;
        logic [7:0]  ctrl_out;
        logic        nmi_pending;
        logic        nmi_immediate;
    } t_rsp;

endpackage

/* hw/rtl/ppu_scroll_address_registers_unit.sv */
// channel   valid    stall    payload  direction
// request   i_valid  o_stall  i_req    in
// result    o_valid  i_stall  o_rsp    out
//
// One request per cycle while the result side does not stall; a taken request goes into the input
// register, then the single update pass loads the result register, which presents the result.
// Synchronous active-low reset clears all scroll, address and flag state.
// A stalled result holds the result register; the input register still takes one more request.
module ppu_scroll_address_registers_unit
    import ppusar_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    logic        r_in_valid;
    t_req        r_in;
    logic        r_out_valid;
    t_rsp        r_out;

    logic [14:0] r_cur,    n_cur;
    logic [14:0] r_tmp,    n_tmp;
    logic [2:0]  r_fine_x, n_fine_x;
    logic        r_toggle, n_toggle;
    logic [7:0]  r_ctrl,   n_ctrl;
    logic        r_vblank, n_vblank;
    logic [7:0]  r_buf,    n_buf;
    logic        r_nmi,    n_nmi;
    logic        r_nmi_now, n_nmi_now;
    t_rsp        n_out;

    logic        advance;
    logic        commit;
    logic        accept;
    logic [13:0] addr14;
    logic [13:0] inc;
    logic [2:0]  fine_y;
    logic [4:0]  coarse_y;
    logic [4:0]  next_cy;
    logic [7:0]  d;

    assign advance = !r_out_valid || !i_stall;
    assign commit  = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    assign addr14   = r_cur[13:0];
    assign inc      = r_ctrl[2] ? INC_DOWN : INC_ACROSS;
    assign fine_y   = r_cur[14:12];
    assign coarse_y = r_cur[9:5];
    assign d        = r_in.bus_data;

    always_comb begin
        if (coarse_y == ROW_LAST || coarse_y == COARSE_LAST) begin
            next_cy = 5'd0;
        end else begin
            next_cy = coarse_y + 5'd1;
        end
    end

    always_comb begin
        n_cur     = r_cur;
        n_tmp     = r_tmp;
        n_fine_x  = r_fine_x;
        n_toggle  = r_toggle;
        n_ctrl    = r_ctrl;
        n_vblank  = r_vblank;
        n_buf     = r_buf;
        n_nmi     = r_nmi;
        n_nmi_now = r_nmi_now;
        n_out.read_data = 8'd0;
        n_out.mem_op    = MEM_NONE;
        n_out.mem_addr  = 14'd0;
        n_out.mem_wdata = 8'd0;
        case (r_in.command)
            CMD_BUS_WRITE: begin
                case (r_in.reg_index)
                    REG_CTRL: begin
                        if (!r_ctrl[7] && d[7] && r_vblank) begin
                            n_nmi_now = 1'b1;
                        end
                        n_ctrl = d;
                        n_tmp  = {r_tmp[14:12], d[1:0], r_tmp[9:0]};
                    end
                    REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_tmp    = {r_tmp[14:5], d[7:3]};
                            n_fine_x = d[2:0];
                            n_toggle = 1'b1;
                        end else begin
                            n_tmp    = {d[2:0], r_tmp[11:10], d[7:3], r_tmp[4:0]};
                            n_toggle = 1'b0;
                        end
                    end
                    REG_ADDR: begin
                        if (!r_toggle) begin
                            n_tmp    = {1'b0, d[5:0], r_tmp[7:0]};
                            n_toggle = 1'b1;
                        end else begin
                            n_tmp    = {r_tmp[14:8], d};
                            n_cur    = {r_tmp[14:8], d};
                            n_toggle = 1'b0;
                        end
                    end
                    REG_DATA: begin
                        n_out.mem_op    = MEM_WRITE;
                        n_out.mem_addr  = addr14;
                        n_out.mem_wdata = d;
                        n_cur           = {1'b0, addr14 + inc};
                    end
                    default: begin
                    end
                endcase
            end
            CMD_BUS_READ: begin
                case (r_in.reg_index)
                    REG_STATUS: begin
                        n_out.read_data = {r_vblank, 7'd0};
                        n_vblank        = 1'b0;
                        n_toggle        = 1'b0;
                    end
                    REG_DATA: begin
                        n_out.mem_op    = MEM_READ;
                        n_out.mem_addr  = addr14;
                        n_out.read_data = r_buf;
                        if (addr14 <= ADDR_NT_LAST) begin
                            n_buf = r_in.mem_byte;
                        end else begin
                            n_buf = r_in.mem_byte_below;
                            if (addr14 >= ADDR_PALETTE) begin
                                n_out.read_data = r_in.mem_byte;
                            end
                        end
                        n_cur = {1'b0, addr14 + inc};
                    end
                    default: begin
                    end
                endcase
            end
            CMD_INC_X: begin
                if (r_cur[4:0] == COARSE_LAST) begin
                    n_cur = {r_cur[14:11], ~r_cur[10], r_cur[9:5], 5'd0};
                end else begin
                    n_cur = r_cur + 15'd1;
                end
            end
            CMD_INC_Y: begin
                if (fine_y != FINE_LAST) begin
                    n_cur = {fine_y + 3'd1, r_cur[11:0]};
                end else begin
                    n_cur = {3'd0, r_cur[11] ^ (coarse_y == ROW_LAST), r_cur[10],
                             next_cy, r_cur[4:0]};
                end
            end
            CMD_COPY_HORIZ: begin
                n_cur = {r_cur[14:11], r_tmp[10], r_cur[9:5], r_tmp[4:0]};
            end
            CMD_COPY_VERT: begin
                n_cur = {r_tmp[14:11], r_cur[10], r_tmp[9:5], r_cur[4:0]};
            end
            CMD_SET_VBLANK: begin
                n_vblank = 1'b1;
                if (r_ctrl[7]) begin
                    n_nmi = 1'b1;
                end
            end
            CMD_FRAME_ST: begin
                n_vblank = 1'b0;
            end
            CMD_NMI_ACK: begin
                n_nmi     = 1'b0;
                n_nmi_now = 1'b0;
            end
            default: begin
            end
        endcase
        n_out.vram_addr     = n_cur;
        n_out.fine_x_out    = n_fine_x;
        n_out.ctrl_out      = n_ctrl;
        n_out.nmi_pending   = n_nmi;
        n_out.nmi_immediate = n_nmi_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur       <= '0;
            r_tmp       <= '0;
            r_fine_x    <= '0;
            r_toggle    <= 1'b0;
            r_ctrl      <= '0;
            r_vblank    <= 1'b0;
            r_buf       <= '0;
            r_nmi       <= 1'b0;
            r_nmi_now   <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (commit) begin
                r_in_valid <= 1'b0;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (commit) begin
                r_cur     <= n_cur;
                r_tmp     <= n_tmp;
                r_fine_x  <= n_fine_x;
                r_toggle  <= n_toggle;
                r_ctrl    <= n_ctrl;
                r_vblank  <= n_vblank;
                r_buf     <= n_buf;
                r_nmi     <= n_nmi;
                r_nmi_now <= n_nmi_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_req;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    a_idle_access_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.mem_op == MEM_NONE) |-> (r_out.mem_addr == 14'd0
            && r_out.mem_wdata == 8'd0))
        else $error("memory address or data set without an access");

    a_nmi_in_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_nmi) |-> (r_vblank && r_ctrl[7]))
        else $error("interrupt raised outside vblank or with interrupts off");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("request stalled while a stage is free");

endmodule
